// ===== hw/rtl/vision_approach_steering_defines.svh =====
// assertion macros for the approach steering block
`ifndef VISION_APPROACH_STEERING_DEFINES_SVH
`define VISION_APPROACH_STEERING_DEFINES_SVH

`ifndef ASSERT_OFF
`define VAS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define VAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define VAS_ASSERT_SAME(label, clk, rst, ante, cons)
`define VAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/vas_pkg.sv =====
package vas_pkg;

   typedef enum logic [1:0] {
      MODE_ILLUM = 2'd0,
      MODE_SEEK  = 2'd1,
      MODE_GRAB  = 2'd2,
      MODE_DONE  = 2'd3
   } mode_type;

   localparam logic [1:0] LIGHT_NONE = 2'd0;
   localparam logic [1:0] LIGHT_ON   = 2'd1;
   localparam logic [1:0] LIGHT_OFF  = 2'd2;

   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_GAIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_FLOOR    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_DECAY    = 3'd4;

   localparam logic [14:0] RST_SPEED_GAIN      = 15'd9830;
   localparam logic [15:0] RST_TURN_GAIN       = 16'hd99a;
   localparam logic [14:0] RST_CLOSE_THRESHOLD = 15'd328;
   localparam logic [14:0] RST_SEARCH_FLOOR    = 15'd4915;
   localparam logic [14:0] RST_SEARCH_DECAY    = 15'd14746;

   localparam logic [15:0] DIR_INIT  = 16'd4915;
   localparam logic [14:0] NEAR_ZERO = 15'd328;
   localparam logic [14:0] Q_ONE     = 15'd16384;
   localparam logic [15:0] S16_MAX   = 16'd32767;
   localparam logic [15:0] S16_MIN_MAG = 16'd32768;

   // floor(mag / 16384 * 4.9) == floor(mag * 49 / 163840), thresholds per index step
   localparam int unsigned IDX_STEP = 163840;
   localparam int unsigned IDX_MUL  = 49;
   localparam int unsigned IDX_TH1 = (1 * IDX_STEP + IDX_MUL - 1) / IDX_MUL;
   localparam int unsigned IDX_TH2 = (2 * IDX_STEP + IDX_MUL - 1) / IDX_MUL;
   localparam int unsigned IDX_TH3 = (3 * IDX_STEP + IDX_MUL - 1) / IDX_MUL;
   localparam int unsigned IDX_TH4 = (4 * IDX_STEP + IDX_MUL - 1) / IDX_MUL;

   localparam logic [14:0] SPEED_TAB [0:4][0:4] = '{
      '{15'd3277, 15'd6554, 15'd13107, 15'd16384, 15'd16384},
      '{15'd0,    15'd3277, 15'd8192,  15'd11469, 15'd11469},
      '{15'd0,    15'd3277, 15'd3277,  15'd6554,  15'd8192},
      '{15'd0,    15'd3277, 15'd3277,  15'd4915,  15'd6554},
      '{15'd0,    15'd3277, 15'd3277,  15'd3277,  15'd4915}
   };
   localparam logic [14:0] ROT_TAB [0:4] = '{
      15'd1638, 15'd3277, 15'd3277, 15'd4915, 15'd6554
   };

   typedef struct packed {
      logic        cmd;
      logic        target_found;
      logic [14:0] distance;
      logic [15:0] direction;
      logic        arm_up;
      logic        claw_open;
   } req_type;

   typedef struct packed {
      logic        drive_valid;
      logic [14:0] drive_speed;
      logic [15:0] drive_turn;
      logic [1:0]  light_cmd;
      logic        lower_arm;
      logic        open_gripper;
      logic        dark_image;
      logic [1:0]  mode_now;
      logic        finished;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic mul1;
      logic rnd;
      logic mul2;
      logic commit;
   } ctrl_cmd_type;

   function automatic logic [2:0] tab_index(input logic [15:0] mag);
      logic [2:0] idx;
      if (32'(mag) >= IDX_TH4) begin
         idx = 3'd4;
      end else if (32'(mag) >= IDX_TH3) begin
         idx = 3'd3;
      end else if (32'(mag) >= IDX_TH2) begin
         idx = 3'd2;
      end else if (32'(mag) >= IDX_TH1) begin
         idx = 3'd1;
      end else begin
         idx = 3'd0;
      end
      return idx;
   endfunction

   // q14 product rounding, half away from zero on magnitudes
   function automatic logic [18:0] q_round(input logic [31:0] prod);
      logic [32:0] sum;
      sum = 33'(prod) + 33'd8192;
      return sum[32:14];
   endfunction

   function automatic logic [15:0] abs16(input logic [15:0] v);
      return v[15] ? 16'(16'd0 - v) : v;
   endfunction

endpackage

// ===== hw/rtl/vas_ctrl.sv =====
module vas_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output vas_pkg::ctrl_cmd_type cmd
);
   import vas_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL1 = 5'b00010,
      S_RND  = 5'b00100,
      S_MUL2 = 5'b01000,
      S_OUT  = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_RND;
         end
         S_RND: begin
            cmd.rnd  = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/vas_dp.sv =====
module vas_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  vas_pkg::ctrl_cmd_type           cmd,
   input  vas_pkg::req_type                req_data,
   input  logic                            csr_we,
   input  logic [vas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]                     csr_wdata,
   output vas_pkg::rsp_type                rsp_data
);
   import vas_pkg::*;

   logic [14:0] speed_gain_ff;
   logic [15:0] turn_gain_ff;
   logic [14:0] close_threshold_ff;
   logic [14:0] search_floor_ff;
   logic [14:0] search_decay_ff;

   mode_type    mode_ff, mode_in;
   logic [15:0] last_dir_ff, last_dir_in;

   req_type     in_ff;
   logic [31:0] prod_ff, prod_in;
   logic [14:0] spd_ff;
   logic [15:0] t_ff, t_in;
   logic        neg_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        dir_neg, ld_neg, decay_on;
   logic [15:0] dir_mag, ld_mag, dec_mag, dec_t, floor_t, rot_t;
   logic [2:0]  dir_idx, dist_idx;
   logic [14:0] spd_entry, rot_mag, trn_mag;
   logic [15:0] mul_a, mul_b;
   logic [18:0] r_val;
   logic        reached;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_gain_ff      <= RST_SPEED_GAIN;
         turn_gain_ff       <= RST_TURN_GAIN;
         close_threshold_ff <= RST_CLOSE_THRESHOLD;
         search_floor_ff    <= RST_SEARCH_FLOOR;
         search_decay_ff    <= RST_SEARCH_DECAY;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPEED_GAIN:      speed_gain_ff      <= csr_wdata[14:0];
            CSR_TURN_GAIN:       turn_gain_ff       <= csr_wdata;
            CSR_CLOSE_THRESHOLD: close_threshold_ff <= csr_wdata[14:0];
            CSR_SEARCH_FLOOR:    search_floor_ff    <= csr_wdata[14:0];
            CSR_SEARCH_DECAY:    search_decay_ff    <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // operand decode
   assign dir_neg   = in_ff.direction[15];
   assign dir_mag   = abs16(in_ff.direction);
   assign dir_idx   = tab_index(dir_mag);
   assign dist_idx  = tab_index({1'b0, in_ff.distance});
   assign spd_entry = (in_ff.distance < NEAR_ZERO) ? 15'd0 : SPEED_TAB[dir_idx][dist_idx];
   assign rot_mag   = ROT_TAB[dir_idx];
   assign rot_t     = dir_neg ? 16'(16'd0 - {1'b0, rot_mag}) : {1'b0, rot_mag};
   assign ld_neg    = last_dir_ff[15];
   assign ld_mag    = abs16(last_dir_ff);
   assign decay_on  = ld_mag >= {1'b0, search_floor_ff};
   assign floor_t   = ld_neg ? 16'(16'd0 - {1'b0, search_floor_ff}) : {1'b0, search_floor_ff};
   assign reached   = in_ff.distance <= close_threshold_ff;

   assign r_val = q_round(prod_ff);

   // saturate the decayed direction to 16 bits signed
   always_comb begin
      if (ld_neg) begin
         dec_mag = (r_val > 19'(S16_MIN_MAG)) ? S16_MIN_MAG : r_val[15:0];
         dec_t   = 16'(16'd0 - dec_mag);
      end else begin
         dec_mag = (r_val > 19'(S16_MAX)) ? S16_MAX : r_val[15:0];
         dec_t   = dec_mag;
      end
   end

   always_comb begin
      if (cmd.mul1) begin
         mul_a = in_ff.target_found ? {1'b0, speed_gain_ff} : ld_mag;
         mul_b = in_ff.target_found ? {1'b0, spd_entry} : {1'b0, search_decay_ff};
      end else begin
         mul_a = abs16(turn_gain_ff);
         mul_b = abs16(t_ff);
      end
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      if (in_ff.target_found) begin
         t_in = rot_t;
      end else if (decay_on) begin
         t_in = dec_t;
      end else begin
         t_in = floor_t;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_data;
      end
      if (cmd.mul1 || cmd.mul2) begin
         prod_ff <= prod_in;
      end
      if (cmd.rnd) begin
         spd_ff <= (r_val > 19'(Q_ONE)) ? Q_ONE : r_val[14:0];
         t_ff   <= t_in;
      end
      if (cmd.mul2) begin
         neg_ff <= turn_gain_ff[15] ^ t_ff[15];
      end
   end

   assign trn_mag = (r_val > 19'(Q_ONE)) ? Q_ONE : r_val[14:0];

   always_comb begin
      rsp_in      = '0;
      mode_in     = mode_ff;
      last_dir_in = last_dir_ff;
      if (!in_ff.cmd) begin
         rsp_in.dark_image = 1'b1;
         mode_in           = MODE_ILLUM;
         last_dir_in       = DIR_INIT;
      end else begin
         unique case (mode_ff)
            MODE_ILLUM: begin
               rsp_in.light_cmd    = LIGHT_ON;
               rsp_in.lower_arm    = in_ff.arm_up;
               rsp_in.open_gripper = !in_ff.claw_open;
               mode_in             = MODE_SEEK;
               last_dir_in         = DIR_INIT;
            end
            MODE_SEEK: begin
               rsp_in.drive_valid = 1'b1;
               if (in_ff.target_found) begin
                  last_dir_in = in_ff.direction;
                  if (reached) begin
                     mode_in = MODE_GRAB;
                  end else begin
                     rsp_in.drive_speed = spd_ff;
                     rsp_in.drive_turn  = neg_ff ? 16'(16'd0 - {1'b0, trn_mag})
                                                 : {1'b0, trn_mag};
                  end
               end else begin
                  if (decay_on) begin
                     last_dir_in = t_ff;
                  end
                  rsp_in.drive_turn = neg_ff ? 16'(16'd0 - {1'b0, trn_mag})
                                             : {1'b0, trn_mag};
               end
            end
            MODE_GRAB: begin
               rsp_in.light_cmd = LIGHT_OFF;
               mode_in          = MODE_DONE;
            end
            MODE_DONE: begin
               rsp_in.light_cmd = LIGHT_OFF;
            end
         endcase
      end
      rsp_in.mode_now = mode_in;
      rsp_in.finished = (mode_in == MODE_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_ILLUM;
         last_dir_ff <= DIR_INIT;
      end else if (cmd.commit) begin
         mode_ff     <= mode_in;
         last_dir_ff <= last_dir_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hw/rtl/vision_approach_steering.sv =====
// approach steering controller: turns vision reports into drive, light, arm
// and claw requests through a four-mode sequence (illuminate, seek, grab, done)
// req channel: one request per control tick, req_valid/req_stall; cmd=0
//   restarts the sequence and asks for a dark exposure
// rsp channel: exactly one result per request, rsp_valid/rsp_stall, held in
//   an output register until taken
// csr channel: register writes by index with csr_valid/csr_ready; ready is
//   always high, writes belong between requests
// the request is registered, then the single shared 16x16 multiplier forms
//   the speed or decay product, a rounding step follows, then the turn
//   product, and the result is registered; no new request is taken before that
// a new request is taken while the previous result still waits; the final
//   step holds until the output register is free, so a stalled receiver
//   holds off the next request after one more is taken
// reset: sync, active high; mode returns to illuminate, remembered direction
//   to 0.3, registers to defaults, both channels empty
`include "vision_approach_steering_defines.svh"

module vision_approach_steering (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  vas_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output vas_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vas_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_wdata
);
   import vas_pkg::*;

   ctrl_cmd_type cmd;
   logic         csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   vas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   vas_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

   `VAS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `VAS_ASSERT_SAME(a_finished_matches_mode, clock, reset, rsp_valid, rsp_data.finished == (rsp_data.mode_now == MODE_DONE))
   `VAS_ASSERT_SAME(a_no_drive_is_zero, clock, reset, rsp_valid && !rsp_data.drive_valid, rsp_data.drive_speed == 15'd0 && rsp_data.drive_turn == 16'd0)
   `VAS_ASSERT_SAME(a_dark_only_on_restart, clock, reset, rsp_valid && rsp_data.dark_image, rsp_data.mode_now == MODE_ILLUM && rsp_data.light_cmd == LIGHT_NONE)

endmodule

// ===== sim/vision_approach_steering_test.sv =====
`timescale 1ns / 1ps

module vision_approach_steering_test;
   import vas_pkg::*;

   localparam int  N_PLAN = 19;
   localparam int  N_PHASE = 13;
   localparam int  PHASE_ITEMS = 140;
   localparam int  LIMIT = 1000000;
   localparam longint HOME_DIR = 4915;
   localparam longint SLOW_DIST = 328;

   localparam logic [0:4][0:4][14:0] FWD_TAB = {
      15'd3277, 15'd6554, 15'd13107, 15'd16384, 15'd16384,
      15'd0,    15'd3277, 15'd8192,  15'd11469, 15'd11469,
      15'd0,    15'd3277, 15'd3277,  15'd6554,  15'd8192,
      15'd0,    15'd3277, 15'd3277,  15'd4915,  15'd6554,
      15'd0,    15'd3277, 15'd3277,  15'd3277,  15'd4915
   };
   localparam logic [0:4][14:0] TURN_TAB = {
      15'd1638, 15'd3277, 15'd3277, 15'd4915, 15'd6554
   };

   typedef struct packed {
      req_type r;
      logic    typed;
      rsp_type t;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SPEED_GAIN;
   logic [15:0]          csr_wdata = '0;

   // predictor state and register copies
   mode_type            mode_q = MODE_ILLUM;
   longint              last_dir = HOME_DIR;
   logic [14:0]         speed_gain_q = 15'd9830;
   logic signed [15:0]  turn_gain_q = -16'sd9830;
   logic [14:0]         close_q = 15'd328;
   logic [14:0]         floor_q = 15'd4915;
   logic [14:0]         decay_q = 15'd14746;

   rsp_type       due_cmds [$];
   rsp_type       want;
   plan_row_type  plan [0:N_PLAN-1];
   int            fails = 0;
   int            cyc = 0;
   int            stall_style = 0;
   int            burst_left = 0;
   bit            idle_on = 1'b1;

   vision_approach_steering u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint q14_mul(longint a, longint b);
      longint ua, ub, p;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = (ua * ub + 8192) >>> 14;
      return ((a < 0) != (b < 0)) ? -p : p;
   endfunction

   function automatic int unsigned grid_index(longint mag);
      longint i;
      i = (mag * 49) / 163840;
      return (i > 4) ? 4 : int'(i);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic rsp_type steer_step(req_type r);
      rsp_type     o;
      longint      dist_val, dir, mag, t, spd, trn;
      int unsigned a, d;
      o = '0;
      spd = 0;
      trn = 0;
      dist_val = longint'(r.distance);
      dir = longint'($signed(r.direction));
      if (!r.cmd) begin
         mode_q = MODE_ILLUM;
         last_dir = HOME_DIR;
         o.dark_image = 1'b1;
      end else begin
         case (mode_q)
            MODE_ILLUM: begin
               o.light_cmd = LIGHT_ON;
               mode_q = MODE_SEEK;
               last_dir = HOME_DIR;
               o.lower_arm = r.arm_up;
               o.open_gripper = !r.claw_open;
            end
            MODE_SEEK: begin
               o.drive_valid = 1'b1;
               if (r.target_found) begin
                  last_dir = dir;
                  if (dist_val <= longint'(close_q)) begin
                     mode_q = MODE_GRAB;
                  end else begin
                     mag = (dir < 0) ? -dir : dir;
                     a = grid_index(mag);
                     d = grid_index(dist_val);
                     spd = (dist_val < SLOW_DIST) ? 0 : longint'(FWD_TAB[a][d]);
                     t = (dir < 0) ? -longint'(TURN_TAB[a]) : longint'(TURN_TAB[a]);
                     spd = q14_mul(longint'(speed_gain_q), spd);
                     trn = q14_mul(longint'(turn_gain_q), t);
                  end
               end else begin
                  mag = (last_dir < 0) ? -last_dir : last_dir;
                  if (mag >= longint'(floor_q)) begin
                     last_dir = clip(q14_mul(last_dir, longint'(decay_q)), -32768, 32767);
                     t = last_dir;
                  end else begin
                     t = (last_dir < 0) ? -longint'(floor_q) : longint'(floor_q);
                  end
                  trn = q14_mul(longint'(turn_gain_q), t);
               end
            end
            MODE_GRAB: begin
               o.light_cmd = LIGHT_OFF;
               mode_q = MODE_DONE;
            end
            default: begin
               o.light_cmd = LIGHT_OFF;
            end
         endcase
      end
      spd = clip(spd, 0, 16384);
      trn = clip(trn, -16384, 16384);
      o.drive_speed = spd[14:0];
      o.drive_turn = trn[15:0];
      o.mode_now = mode_q;
      o.finished = (mode_q == MODE_DONE);
      return o;
   endfunction

   function automatic req_type mk_req(bit cmd, bit found, int dist_val, int dir,
                                      bit arm, bit claw);
      req_type r;
      r.cmd = cmd;
      r.target_found = found;
      r.distance = dist_val[14:0];
      r.direction = dir[15:0];
      r.arm_up = arm;
      r.claw_open = claw;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(bit dv, logic [1:0] light, bit lower, bit opn, bit dark,
                                      mode_type m);
      rsp_type o;
      o = '0;
      o.drive_valid = dv;
      o.light_cmd = light;
      o.lower_arm = lower;
      o.open_gripper = opn;
      o.dark_image = dark;
      o.mode_now = m;
      o.finished = (m == MODE_DONE);
      return o;
   endfunction

   function automatic req_type draw_tick();
      req_type r;
      int      pick;
      r = '0;
      r.cmd = 1'b1;
      if ($urandom_range(0, 19) == 0 || (mode_q == MODE_DONE && $urandom_range(0, 9) < 4)) begin
         r.cmd = 1'b0;
      end
      r.target_found = ($urandom_range(0, 9) < 7);
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         r.distance = 15'(clip(longint'(close_q) + $urandom_range(0, 6) - 3, 0, 32767));
      end else if (pick < 4) begin
         r.distance = 15'($urandom_range(0, 340));
      end else if (pick == 4) begin
         r.distance = 15'($urandom);
      end else begin
         r.distance = 15'($urandom_range(0, 16384));
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         r.direction = 16'($urandom);
      end else if (pick < 3) begin
         r.direction = 16'(int'($urandom_range(0, 800)) - 400);
      end else begin
         r.direction = 16'(int'($urandom_range(0, 32768)) - 16384);
      end
      r.arm_up = 1'($urandom_range(0, 1));
      r.claw_open = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function void diff(string name, longint w, longint g);
      if (w != g) begin
         $display("%0t %s expected %0d actual %0d", $time, name, w, g);
         fails++;
      end
   endfunction

   task automatic put_req(req_type r, logic typed, rsp_type t);
      rsp_type o;
      int      gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = idle_on ? $urandom_range(0, 15) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      o = steer_step(r);
      due_cmds.push_back(typed ? t : o);
   endtask

   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SPEED_GAIN:      speed_gain_q = v[14:0];
         CSR_TURN_GAIN:       turn_gain_q = v;
         CSR_CLOSE_THRESHOLD: close_q = v[14:0];
         CSR_SEARCH_FLOOR:    floor_q = v[14:0];
         CSR_SEARCH_DECAY:    decay_q = v[14:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (due_cmds.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_gains(logic [15:0] sg, logic [15:0] tg, logic [15:0] th,
                             logic [15:0] fl, logic [15:0] dc);
      csr_put(CSR_SPEED_GAIN, sg);
      csr_put(CSR_TURN_GAIN, tg);
      csr_put(CSR_CLOSE_THRESHOLD, th);
      csr_put(CSR_SEARCH_FLOOR, fl);
      csr_put(CSR_SEARCH_DECAY, dc);
      csr_valid <= 1'b0;
   endtask

   // cycle count, timeout and receiver stall pattern
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc == LIMIT) begin
         $display("tb: failure");
         $finish;
      end
      if (cyc % 256 == 0) begin
         stall_style <= $urandom_range(0, 3);
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= ((cyc % 40) < 25);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_cmds.size() == 0) begin
            $display("%0t unexpected result, expected none actual %p", $time, rsp_data);
            fails++;
         end else begin
            want = due_cmds.pop_front();
            diff("drive_valid", want.drive_valid, rsp_data.drive_valid);
            diff("drive_speed", want.drive_speed, rsp_data.drive_speed);
            diff("drive_turn", $signed(want.drive_turn), $signed(rsp_data.drive_turn));
            diff("light_cmd", want.light_cmd, rsp_data.light_cmd);
            diff("lower_arm", want.lower_arm, rsp_data.lower_arm);
            diff("open_gripper", want.open_gripper, rsp_data.open_gripper);
            diff("dark_image", want.dark_image, rsp_data.dark_image);
            diff("mode_now", want.mode_now, rsp_data.mode_now);
            diff("finished", want.finished, rsp_data.finished);
         end
      end
   end

   initial begin
      plan[0]  = {mk_req(0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, LIGHT_NONE, 0, 0, 1, MODE_ILLUM)};
      plan[1]  = {mk_req(1, 0, 0, 0, 0, 1), 1'b1, mk_rsp(0, LIGHT_ON, 0, 0, 0, MODE_SEEK)};
      plan[2]  = {mk_req(0, 1, 16384, 16384, 1, 1), 1'b1,
                  mk_rsp(0, LIGHT_NONE, 0, 0, 1, MODE_ILLUM)};
      plan[3]  = {mk_req(1, 1, 0, -1, 1, 0), 1'b1, mk_rsp(0, LIGHT_ON, 1, 1, 0, MODE_SEEK)};
      plan[4]  = {mk_req(1, 1, 16384, 16384, 0, 0), 1'b0, rsp_type'('0)};
      plan[5]  = {mk_req(1, 1, 16384, -16384, 0, 0), 1'b0, rsp_type'('0)};
      plan[6]  = {mk_req(1, 1, 329, 0, 0, 0), 1'b0, rsp_type'('0)};
      plan[7]  = {mk_req(1, 1, 32767, -32768, 1, 1), 1'b0, rsp_type'('0)};
      plan[8]  = {mk_req(1, 1, 1000, 32767, 0, 0), 1'b0, rsp_type'('0)};
      plan[9]  = {mk_req(1, 0, 0, 0, 0, 0), 1'b0, rsp_type'('0)};
      plan[10] = {mk_req(1, 0, 500, 200, 1, 0), 1'b0, rsp_type'('0)};
      plan[11] = {mk_req(1, 0, 0, 0, 0, 1), 1'b0, rsp_type'('0)};
      plan[12] = {mk_req(1, 0, 0, 0, 0, 0), 1'b0, rsp_type'('0)};
      plan[13] = {mk_req(1, 1, 16384, -100, 0, 0), 1'b0, rsp_type'('0)};
      plan[14] = {mk_req(1, 0, 0, 0, 0, 0), 1'b0, rsp_type'('0)};
      plan[15] = {mk_req(1, 1, 328, 5000, 0, 0), 1'b1, mk_rsp(1, LIGHT_NONE, 0, 0, 0, MODE_GRAB)};
      plan[16] = {mk_req(1, 1, 0, 0, 0, 0), 1'b1, mk_rsp(0, LIGHT_OFF, 0, 0, 0, MODE_DONE)};
      plan[17] = {mk_req(1, 0, 16384, 16384, 1, 0), 1'b1,
                  mk_rsp(0, LIGHT_OFF, 0, 0, 0, MODE_DONE)};
      plan[18] = {mk_req(0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, LIGHT_NONE, 0, 0, 1, MODE_ILLUM)};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_PLAN; i++) begin
         put_req(plan[i].r, plan[i].typed, plan[i].t);
      end

      for (int p = 0; p < N_PHASE; p++) begin
         if (p > 0) begin
            drain();
            case (p)
               1: load_gains(16'd0, 16'(-16384), 16'd0, 16'd0, 16'd0);
               2: load_gains(16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd16384);
               3: load_gains(16'd9830, 16'(-9830), 16'd328, 16'd4915, 16'd14746);
               4: load_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom));
               default: load_gains(16'($urandom_range(0, 16384)),
                                   16'(int'($urandom_range(0, 32768)) - 16384),
                                   16'($urandom_range(0, 1) ? $urandom_range(0, 2000)
                                                            : $urandom_range(0, 16384)),
                                   16'($urandom_range(0, 16384)),
                                   16'($urandom_range(0, 16384)));
            endcase
            burst_left = 0;
         end
         idle_on = (p % 4 != 2);
         repeat (PHASE_ITEMS) put_req(draw_tick(), 1'b0, rsp_type'('0));
      end

      drain();
      repeat (20) @(posedge clock);
      if (fails == 0 && due_cmds.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/vas_pkg.sv
hw/rtl/vas_ctrl.sv
hw/rtl/vas_dp.sv
hw/rtl/vision_approach_steering.sv
sim/vision_approach_steering_test.sv
